@@ hdl/pkic_pkg.sv @@
// Package for the path keyword I/O classifier: window type and category codes.
// No dependencies.
`default_nettype none
package pkic_pkg;
  localparam int WIN = 10;
  localparam int PFX_LEN = 11;
  localparam int NGROUPS = 17;
  typedef logic [7:0] byte_t;
  typedef logic [6:0] code_t;
  typedef logic [2:0] prim_t;

  localparam code_t CODE_NONE    = 7'd0;
  localparam code_t CODE_BUCKET  = 7'd10;
  localparam code_t CODE_DATA    = 7'd13;
  localparam code_t CODE_SYS     = 7'd20;

  // Subcategory code handed from the front to the back stage for one finished path
  typedef struct packed {
    code_t sec;
  } result_t;

  // primary category is the tens digit of the subcategory (values below 80)
  function automatic prim_t prim_of(input code_t c);
    logic [13:0] prod;
    prod = 14'(c) * 14'd103;
    return prim_t'(prod >> 10);
  endfunction
endpackage
`default_nettype wire

@@ hdl/pkic_front.sv @@
// Front stage: takes path bytes, runs the window detectors, emits one code per path.
// Uses pkic_pkg.
`default_nettype none
module pkic_front #(
  parameter int PATH_BYTES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire pkic_pkg::byte_t    path_byte,
  input  wire logic               end_of_path,
  output pkic_pkg::result_t       res,
  output logic                    res_valid
);
  localparam int PW = $clog2(PATH_BYTES + 1);

  pkic_pkg::byte_t w [pkic_pkg::WIN];
  pkic_pkg::byte_t nw [pkic_pkg::WIN];
  logic [PW-1:0] pos;
  logic ended, pfx_ok, dseen, armed, bseen, oseen;
  pkic_pkg::code_t psub;
  pkic_pkg::code_t hit [pkic_pkg::NGROUPS];
  pkic_pkg::code_t hit_next [pkic_pkg::NGROUPS];
  pkic_pkg::code_t psub_next, sec;
  logic take, pfx_next, d_next, a_next, b_next, o_next, ended_next;
  logic [PW-1:0] pos_next;

  // window after shifting the byte in
  always_comb begin
    nw[0] = path_byte;
    for (int i = 1; i < pkic_pkg::WIN; i++) nw[i] = w[i-1];
  end

  function automatic logic m3(input pkic_pkg::byte_t a [pkic_pkg::WIN],
                              input logic [23:0] s);
    return a[2] == s[23:16] && a[1] == s[15:8] && a[0] == s[7:0];
  endfunction
  function automatic logic m4(input pkic_pkg::byte_t a [pkic_pkg::WIN],
                              input logic [31:0] s);
    return a[3] == s[31:24] && a[2] == s[23:16] && a[1] == s[15:8] && a[0] == s[7:0];
  endfunction
  function automatic logic m5(input pkic_pkg::byte_t a [pkic_pkg::WIN],
                              input logic [39:0] s);
    return a[4] == s[39:32] && m4(a, s[31:0]);
  endfunction
  function automatic logic m6(input pkic_pkg::byte_t a [pkic_pkg::WIN],
                              input logic [47:0] s);
    return a[5] == s[47:40] && m5(a, s[39:0]);
  endfunction
  function automatic logic m7(input pkic_pkg::byte_t a [pkic_pkg::WIN],
                              input logic [55:0] s);
    return a[6] == s[55:48] && m6(a, s[47:0]);
  endfunction
  function automatic logic m9(input pkic_pkg::byte_t a [pkic_pkg::WIN],
                              input logic [71:0] s);
    return a[8] == s[71:64] && a[7] == s[63:56] && m7(a, s[55:0]);
  endfunction

  // detector hits per group, code of first matching detector
  pkic_pkg::code_t det [pkic_pkg::NGROUPS];
  always_comb begin
    for (int g = 0; g < pkic_pkg::NGROUPS; g++) det[g] = pkic_pkg::CODE_NONE;
    if (m7(nw, "xl.meta")) det[0] = 7'd21;
    if (m3(nw, "wal") || m3(nw, "WAL")) det[1] = 7'd30;
    if (m4(nw, "raft") || m4(nw, ".log")) det[2] = 7'd31;
    if (m5(nw, "trans")) det[3] = 7'd32;
    if (m7(nw, "journal") || m4(nw, "jbd2")) det[4] = 7'd50;
    if (m6(nw, {"x", "fslog"})) det[5] = 7'd51;
    if (m9(nw, "multipart")) det[6] = 7'd60;
    if (m5(nw, "/tmp/")) det[7] = 7'd61;
    else if (m4(nw, ".tmp") || m5(nw, ".part")) det[7] = 7'd60;
    if (m6(nw, "config") || m4(nw, ".env") || m5(nw, ".yaml") || m5(nw, ".json"))
      det[8] = 7'd70;
    if (m4(nw, ".crt") || m4(nw, ".pem") || m4(nw, ".key")) det[9] = 7'd71;
    if (m6(nw, "access")) det[10] = 7'd72;
    else if (m5(nw, "error")) det[10] = 7'd73;
    else if (m5(nw, "audit")) det[10] = 7'd74;
    if (m4(nw, "lock")) det[11] = 7'd76;
    if (m3(nw, "xl.")) det[12] = 7'd41;
    if (m4(nw, "heal")) det[13] = 7'd42;
    if (m7(nw, "replica")) det[14] = 7'd40;
    if (m6(nw, "pg_wal")) det[15] = 7'd30;
    if (m5(nw, "cache")) det[16] = 7'd63;
  end

  // per-byte state update
  always_comb begin
    logic [7:0] pc;
    pc = 8'h00;
    take = !ended && path_byte != 8'h00 && pos < PW'(PATH_BYTES);
    ended_next = ended || (path_byte == 8'h00) || pos >= PW'(PATH_BYTES);
    pfx_next = pfx_ok;
    psub_next = psub;
    d_next = dseen;
    a_next = armed;
    b_next = bseen;
    o_next = oseen;
    pos_next = pos;
    for (int g = 0; g < pkic_pkg::NGROUPS; g++) hit_next[g] = hit[g];
    if (take) begin
      case (pos[3:0])
        4'd0: pc = ".";
        4'd1: pc = "m";
        4'd2: pc = "i";
        4'd3: pc = "n";
        4'd4: pc = "i";
        4'd5: pc = "o";
        4'd6: pc = ".";
        4'd7: pc = "s";
        4'd8: pc = "y";
        4'd9: pc = "s";
        4'd10: pc = "/";
        default: pc = 8'h00;
      endcase
      if (pos < PW'(pkic_pkg::PFX_LEN)) begin
        if (path_byte != pc) pfx_next = 1'b0;
      end else if (pfx_ok && psub == pkic_pkg::CODE_NONE) begin
        if (pos == PW'(17) && m7(nw, "buckets")) psub_next = 7'd22;
        if (pos == PW'(16) && m6(nw, "config")) psub_next = 7'd70;
        if (pos == PW'(19) && m9(nw, "multipart")) psub_next = 7'd60;
        if (pos == PW'(13) && m3(nw, "tmp")) psub_next = 7'd62;
        if (pos == PW'(14) && m4(nw, "heal")) psub_next = 7'd42;
      end
      for (int g = 0; g < pkic_pkg::NGROUPS; g++)
        if (hit[g] == pkic_pkg::CODE_NONE) hit_next[g] = det[g];
      if (m4(nw, "data") || m5(nw, "/disk")) d_next = 1'b1;
      if (m4(nw, ".dat") || m4(nw, ".bin") || m4(nw, ".obj") || m4(nw, ".jpg") ||
          m4(nw, ".png") || m4(nw, ".pdf")) o_next = 1'b1;
      a_next = armed || (pos != '0 && w[0] == "/" && path_byte != ".");
      if (a_next && path_byte == "/") b_next = 1'b1;
      pos_next = pos + PW'(1);
      if (pos_next >= PW'(PATH_BYTES)) ended_next = 1'b1;
    end
  end

  // classify from next-state values
  always_comb begin
    sec = pkic_pkg::CODE_NONE;
    if (d_next || b_next || o_next) sec = b_next ? pkic_pkg::CODE_BUCKET : pkic_pkg::CODE_DATA;
    for (int g = pkic_pkg::NGROUPS - 1; g >= 0; g--)
      if (hit_next[g] != pkic_pkg::CODE_NONE) sec = hit_next[g];
    if (pfx_next && pos_next >= PW'(pkic_pkg::PFX_LEN))
      sec = (psub_next != pkic_pkg::CODE_NONE) ? psub_next : pkic_pkg::CODE_SYS;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= in_fire && end_of_path;
    end
    if (in_fire) res.sec <= sec;
    if (rst || (in_fire && end_of_path)) begin
      for (int i = 0; i < pkic_pkg::WIN; i++) w[i] <= 8'h00;
      for (int g = 0; g < pkic_pkg::NGROUPS; g++) hit[g] <= pkic_pkg::CODE_NONE;
      pos <= '0;
      ended <= 1'b0;
      pfx_ok <= 1'b1;
      psub <= pkic_pkg::CODE_NONE;
      dseen <= 1'b0;
      armed <= 1'b0;
      bseen <= 1'b0;
      oseen <= 1'b0;
    end else if (in_fire) begin
      if (take) for (int i = 0; i < pkic_pkg::WIN; i++) w[i] <= nw[i];
      for (int g = 0; g < pkic_pkg::NGROUPS; g++) hit[g] <= hit_next[g];
      pos <= pos_next;
      ended <= ended_next;
      pfx_ok <= pfx_next;
      psub <= psub_next;
      dseen <= d_next;
      armed <= a_next;
      bseen <= b_next;
      oseen <= o_next;
    end
  end
endmodule
`default_nettype wire

@@ hdl/pkic_queue.sv @@
// Two-entry result queue between front and back stage.
// Uses pkic_pkg.
`default_nettype none
module pkic_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire pkic_pkg::result_t wdata,
  input  wire logic              rd,
  output pkic_pkg::result_t      rdata,
  output logic                   nonempty,
  output logic                   full
);
  pkic_pkg::result_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign nonempty = cnt != 2'd0;
  assign full = cnt == 2'd2;
  assign rdata = mem[rp];

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
    if (wr) mem[wp] <= wdata;
  end
endmodule
`default_nettype wire

@@ hdl/pkic_back.sv @@
// Back stage: output register that maps a subcategory to both result fields.
// Uses pkic_pkg.
`default_nettype none
module pkic_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_nonempty,
  input  wire pkic_pkg::result_t q_data,
  output logic                   q_rd,
  output logic                   valid,
  input  wire logic              stall,
  output pkic_pkg::prim_t        io_class,
  output pkic_pkg::code_t        io_subclass
);
  assign q_rd = q_nonempty && (!valid || !stall);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || !stall) begin
      valid <= q_nonempty;
    end
    if (q_rd) begin
      io_subclass <= q_data.sec;
      io_class <= pkic_pkg::prim_of(q_data.sec);
    end
  end
endmodule
`default_nettype wire

@@ hdl/path_keyword_io_classifier_top.sv @@
// Path keyword I/O classifier: one path byte per cycle in, one category pair per path out.
// Takes one byte every cycle while in_stall is low. The result of a path passes the
// front register, the queue and the output register after its end_of_path byte is
// accepted. Input stalls when the result queue, counting a result still leaving the
// front stage, would hold two entries after this cycle's read, which only happens
// while the output is held.
`default_nettype none
module path_keyword_io_classifier_top #(
  parameter int PATH_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] path_byte,
  input  wire logic       end_of_path,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      io_class,
  output logic [6:0]      io_subclass
);
  pkic_pkg::result_t fres, qdata;
  logic fvalid, qne, qfull, qrd, in_fire, qwr_busy;

  // stall if queue could overflow: entries plus a result in flight, less this cycle's read, reach two
  logic [1:0] pend;
  assign pend = 2'(qfull) + 2'(qne) + 2'(fvalid) - 2'(qrd);
  assign in_stall = pend >= 2'd2;
  assign in_fire = in_valid && !in_stall;
  assign qwr_busy = fvalid;

  pkic_front #(.PATH_BYTES(PATH_BYTES)) u_front (
    .clk, .rst, .in_fire, .path_byte, .end_of_path, .res(fres), .res_valid(fvalid)
  );
  pkic_queue u_queue (
    .clk, .rst, .wr(qwr_busy), .wdata(fres), .rd(qrd), .rdata(qdata),
    .nonempty(qne), .full(qfull)
  );
  pkic_back u_back (
    .clk, .rst, .q_nonempty(qne), .q_data(qdata), .q_rd(qrd), .valid(out_valid),
    .stall(out_stall), .io_class, .io_subclass
  );
endmodule
`default_nettype wire

@@ hdl/pkic_checker.sv @@
// Port-level checks for the classifier and bind to the top level.
// Uses only the top level ports.
`default_nettype none
module pkic_props (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       end_of_path,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] io_class,
  input wire logic [6:0] io_subclass
);
  // held result keeps its subcategory value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(io_subclass))
    else $error("held result changed");
  // primary is tens digit
  a_prim: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> io_class == 3'(io_subclass / 7'd10))
    else $error("primary mismatch");
  // a path end taken with no reset since must show up: the output may not stay empty
  a_none: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 !out_valid |->
      !$past(in_valid && !in_stall && end_of_path && !rst, 3) ||
      $past(rst, 1) || $past(rst, 2))
    else $error("result lost");
  // input not stalled while out_valid and its $past value are both low
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !$past(out_valid) |-> !in_stall)
    else $error("needless stall");
endmodule

bind path_keyword_io_classifier_top pkic_props u_chk (
  .clk, .rst, .in_valid, .in_stall, .end_of_path, .out_valid, .out_stall,
  .io_class, .io_subclass
);
`default_nettype wire
